/* rtl/key_matrix_emulator_debounce_macros.svh */
// Assertion macros shared by the key matrix emulator RTL.
// Users must provide clk_i and rst_ni in the module that expands them.
`ifndef KEY_MATRIX_EMULATOR_DEBOUNCE_MACROS_SVH
`define KEY_MATRIX_EMULATOR_DEBOUNCE_MACROS_SVH

// Implication or sequence property, checked outside reset.
`define KMED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain invariant that must hold on every clock edge outside reset.
`define KMED_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

/* rtl/kmed_pkg.sv */
// Types, codes and helper functions for the key matrix emulator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kmed_pkg;

  // Request codes of an input beat.
  typedef enum logic [1:0] {
    REQ_MATRIX  = 2'd0,
    REQ_AUX     = 2'd1,
    REQ_PRESS   = 2'd2,
    REQ_RELEASE = 2'd3
  } req_type_e;

  // One input beat.
  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  column_levels;
    logic [7:0]  row_levels;
    logic [3:0]  cmd_row;
    logic [3:0]  cmd_column;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic       is_event;
    logic       pressed;
    logic [2:0] event_row;
    logic [2:0] event_column;
    logic [7:0] drive_mask;
    logic       drive_aux;
    logic       drive_low;
    logic       cmd_error;
    logic       last;
  } res_t;

  // Work handed from the front end to the back end: a set of rows to report
  // as events, followed by one closing drive or acknowledge beat.
  typedef struct packed {
    logic [7:0] report;
    logic [7:0] rows;
    logic [2:0] column;
    logic [7:0] drive_mask;
    logic       drive_aux;
    logic       drive_low;
    logic       cmd_error;
  } job_t;

  // Number of set bits in a byte.
  function automatic logic [3:0] count_ones(logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

  // Index of the highest set bit (zero when none is set).
  function automatic logic [2:0] high_bit(logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Index of the lowest set bit (zero when none is set).
  function automatic logic [2:0] low_bit(logic [7:0] v);
    logic [2:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/key_matrix_emulator_debounce.sv */
// Flow: a job passes through the job queue into the back-end job register.
// Throughput: one input beat per cycle while the job queue has room; each job
// gives one to nine result beats from the back end, one per cycle while popped.
// Reset: asynchronous, active low; polarity resets to active low, all forced
// and debounce state to zero, job queue and result register to empty.
`timescale 1ns / 1ps

module key_matrix_emulator_debounce #(
  parameter int NUM_COLUMNS = 6,
  parameter int NUM_ROWS    = 8,
  parameter int NUM_AUX     = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  kmed_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output kmed_pkg::res_t res_o
);
  import kmed_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  logic accept;
  logic job_valid, q_valid, q_take;
  job_t job, q_job;

  assign accept = push && !full;

  // Front end: decode and state update.
  kmed_front #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_ROWS   (NUM_ROWS),
    .NUM_AUX    (NUM_AUX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  // Job queue between the two halves.
  kmed_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept && job_valid),
    .wr_data_i(job),
    .full_o   (full),
    .rd_i     (q_take),
    .valid_o  (q_valid),
    .rd_data_o(q_job)
  );

  // Back end: result beat sequencing.
  kmed_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (q_job),
    .job_take_o (q_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res_o)
  );

endmodule

/* rtl/kmed_fifo.sv */
// Short job queue between the front end and the back end.
// Depends on kmed_pkg (job_t) and the assertion macros header.
`timescale 1ns / 1ps
`include "key_matrix_emulator_debounce_macros.svh"

module kmed_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  kmed_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output kmed_pkg::job_t rd_data_o
);
  import kmed_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             wr_en, rd_en;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage is payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers wrap at the last entry; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `KMED_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "job queue count overflow")
  `KMED_ASSERT(a_count_dec,
               (rd_en && !wr_en) |=> (count_q == $past(count_q) - 1'b1),
               "job queue count did not drop on a read")
  `KMED_ASSERT(a_count_both, (rd_en && wr_en) |=> $stable(count_q),
               "job queue count moved on read and write")

endmodule

/* rtl/kmed_front.sv */
// Front end: decodes each input beat, keeps the polarity, forced and
// debounce state, and turns each beat into at most one job. Uses kmed_pkg.
`timescale 1ns / 1ps

module kmed_front #(
  parameter int NUM_COLUMNS = 6,
  parameter int NUM_ROWS    = 8,
  parameter int NUM_AUX     = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  kmed_pkg::req_t req_i,
  output logic           job_valid_o,
  output kmed_pkg::job_t job_o
);
  import kmed_pkg::*;

  localparam int         NSLOTS   = NUM_COLUMNS + 1;
  localparam int         SLOT_W   = $clog2(NSLOTS);
  localparam logic [7:0] ROW_MASK = 8'((1 << NUM_ROWS) - 1);
  localparam logic [7:0] COL_MASK = 8'((1 << NUM_COLUMNS) - 1);
  localparam logic [7:0] AUX_MASK = 8'((1 << NUM_AUX) - 1);

  logic              pol_q, pol_d;
  logic [7:0]        forced_q   [NSLOTS];
  logic [7:0]        last_q     [NSLOTS];
  logic [7:0]        prior_q    [NSLOTS];
  logic [7:0]        reported_q [NSLOTS];

  logic [7:0]        act_keep, act_flip, act_f;
  logic [3:0]        cnt_keep, cnt_flip, cnt_f;
  logic              inv_f;
  logic              do_deb, cmd_we, cmd_err;
  logic [SLOT_W-1:0] slot, cmd_slot;
  logic [7:0]        rows, report, changed, changed2, row_bit;

  // Column decode under the current and the flipped polarity.
  assign act_keep = (req_i.column_levels ^ {8{pol_q}}) & COL_MASK;
  assign act_flip = (req_i.column_levels ^ {8{~pol_q}}) & COL_MASK;
  assign cnt_keep = count_ones(act_keep);
  assign cnt_flip = count_ones(act_flip);

  // Command range check.
  assign cmd_err = (req_i.cmd_row >= 4'(NUM_ROWS)) ||
                   (req_i.cmd_column > 4'(NUM_COLUMNS)) ||
                   ((req_i.cmd_column == 4'(NUM_COLUMNS)) &&
                    (req_i.cmd_row >= 4'(NUM_AUX)));
  assign cmd_slot = req_i.cmd_column[SLOT_W-1:0];
  assign row_bit  = 8'd1 << req_i.cmd_row[2:0];

  // Debounce of the selected slot: a row reports when it changed at the last
  // sample, is stable now, differs from the reported state and is not forced.
  assign changed  = last_q[slot] ^ rows;
  assign changed2 = last_q[slot] ^ prior_q[slot];
  assign report   = changed2 & ~changed & (reported_q[slot] ^ rows) & ~forced_q[slot];

  // Classification of the beat.
  always_comb begin
    pol_d       = pol_q;
    act_f       = act_keep;
    cnt_f       = cnt_keep;
    inv_f       = pol_q;
    do_deb      = 1'b0;
    cmd_we      = 1'b0;
    slot        = '0;
    rows        = '0;
    job_valid_o = 1'b0;
    job_o       = '0;
    case (req_i.req_type)
      REQ_MATRIX: begin
        if ((cnt_keep != 4'd1) && (cnt_keep == 4'(NUM_COLUMNS - 1))) begin
          pol_d = ~pol_q;
          act_f = act_flip;
          cnt_f = cnt_flip;
          inv_f = ~pol_q;
        end else if (cnt_keep == 4'(NUM_COLUMNS)) begin
          pol_d = ~pol_q;
        end
        if (cnt_f == 4'd1) begin
          do_deb            = 1'b1;
          slot              = SLOT_W'(high_bit(act_f));
          rows              = (req_i.row_levels ^ {8{inv_f}}) & ROW_MASK;
          job_valid_o       = 1'b1;
          job_o.report      = report;
          job_o.rows        = rows;
          job_o.column      = high_bit(act_f);
          job_o.drive_mask  = forced_q[slot];
          job_o.drive_low   = inv_f;
        end else if (cnt_f == 4'd0) begin
          job_valid_o       = 1'b1;
          job_o.drive_low   = inv_f;
        end
      end
      REQ_AUX: begin
        do_deb            = 1'b1;
        slot              = SLOT_W'(NUM_COLUMNS);
        rows              = req_i.row_levels & AUX_MASK;
        job_valid_o       = 1'b1;
        job_o.report      = report;
        job_o.rows        = rows;
        job_o.column      = 3'(NUM_COLUMNS);
        job_o.drive_mask  = forced_q[slot] & AUX_MASK;
        job_o.drive_aux   = 1'b1;
      end
      default: begin
        cmd_we            = !cmd_err;
        job_valid_o       = 1'b1;
        job_o.cmd_error   = cmd_err;
      end
    endcase
  end

  // State update on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= 1'b1;
      for (int i = 0; i < NSLOTS; i++) begin
        forced_q[i]   <= '0;
        last_q[i]     <= '0;
        prior_q[i]    <= '0;
        reported_q[i] <= '0;
      end
    end else if (accept_i) begin
      pol_q <= pol_d;
      if (do_deb) begin
        reported_q[slot] <= (reported_q[slot] & ~report) | (rows & report);
        prior_q[slot]    <= last_q[slot];
        last_q[slot]     <= rows;
      end
      if (cmd_we) begin
        if (req_i.req_type == REQ_PRESS) begin
          forced_q[cmd_slot] <= forced_q[cmd_slot] | row_bit;
        end else begin
          forced_q[cmd_slot] <= forced_q[cmd_slot] & ~row_bit;
        end
      end
    end
  end

endmodule

/* rtl/kmed_back.sv */
// Back end: expands one job into its event beats, lowest row first, and a
// closing drive or acknowledge beat. Uses kmed_pkg and the macros header.
`timescale 1ns / 1ps
`include "key_matrix_emulator_debounce_macros.svh"

module kmed_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  kmed_pkg::job_t job_i,
  output logic           job_take_o,
  output logic           empty_o,
  input  logic           pop_i,
  output kmed_pkg::res_t res_o
);
  import kmed_pkg::*;

  job_t       job_q;
  logic       valid_q;
  logic [2:0] idx;
  logic       tail;

  assign empty_o    = !valid_q;
  assign idx        = low_bit(job_q.report);
  assign tail       = (job_q.report == '0);
  assign job_take_o = job_valid_i && (!valid_q || (pop_i && tail));

  // Current result beat from the job register.
  always_comb begin
    res_o = '0;
    if (!tail) begin
      res_o.is_event     = 1'b1;
      res_o.pressed      = job_q.rows[idx];
      res_o.event_row    = idx;
      res_o.event_column = job_q.column;
    end else begin
      res_o.drive_mask = job_q.drive_mask;
      res_o.drive_aux  = job_q.drive_aux;
      res_o.drive_low  = job_q.drive_low;
      res_o.cmd_error  = job_q.cmd_error;
      res_o.last       = 1'b1;
    end
  end

  // Job occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i && valid_q && tail) begin
      valid_q <= 1'b0;
    end
  end

  // Job payload; each popped event clears its row from the report set.
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
    end else if (pop_i && valid_q && !tail) begin
      job_q.report <= job_q.report & (job_q.report - 8'd1);
    end
  end

  `KMED_ASSERT(a_last_no_event, (!empty_o && res_o.last) |-> !res_o.is_event,
               "closing beat flagged as event")
  `KMED_ASSERT(a_event_holds, (pop_i && !empty_o && !res_o.last) |=> !empty_o,
               "job lost after an event beat")
  `KMED_ASSERT(a_drain_empty,
               (pop_i && !empty_o && res_o.last && !job_valid_i) |=> empty_o,
               "result shown with no job")

endmodule
